>>> rtl/core/csr_pkg.sv
// Package for the Copeland score ranker: sizes, score limits and the
// controller state type. No dependencies; every other file in rtl/core uses it.
package csr_pkg;

	// Storage sizing
	localparam int MAX_CAND  = 64;
	localparam int CAND_W    = $clog2(MAX_CAND);
	localparam int CNT_W     = $clog2(MAX_CAND + 1);
	localparam int SCORE_CAP = 2 * (MAX_CAND - 1);
	localparam int SCORE_W   = $clog2(SCORE_CAP + 1);
	localparam int MARGIN_W  = 16;

	// Fixed field widths on the channels and the register port
	localparam int IDX_W     = 6;
	localparam int SOUT_W    = 7;
	localparam int CFG_W     = 7;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// Register indexes
	localparam logic [APB_AW-3:0] REG_CAND_COUNT = '0;

	localparam logic [CFG_W-1:0] CAND_COUNT_RST = CFG_W'(64);

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_SCAN,
		ST_PICK,
		ST_EMIT,
		ST_CLEAR
	} state_t;

endpackage

>>> rtl/core/csr_entry_if.sv
// Input channel of the Copeland score ranker: one margin matrix entry per beat.
// Depends on csr_pkg for field widths.
interface csr_entry_if;
	logic                              valid;
	logic                              ready;
	logic [csr_pkg::IDX_W-1:0]         row_cand;
	logic [csr_pkg::IDX_W-1:0]         col_cand;
	logic signed [csr_pkg::MARGIN_W-1:0] margin;
	logic                              final_entry;

	modport source (output valid, row_cand, col_cand, margin, final_entry, input ready);
	modport sink   (input valid, row_cand, col_cand, margin, final_entry, output ready);
endinterface

>>> rtl/core/csr_rank_if.sv
// Output channel of the Copeland score ranker: one ranking position per beat.
// Depends on csr_pkg for field widths.
interface csr_rank_if;
	logic                        valid;
	logic                        ready;
	logic [csr_pkg::IDX_W-1:0]   rank_pos;
	logic [csr_pkg::IDX_W-1:0]   cand_index;
	logic [csr_pkg::SOUT_W-1:0]  score_halves;
	logic                        last_rank;

	modport source (output valid, rank_pos, cand_index, score_halves, last_rank, input ready);
	modport sink   (input valid, rank_pos, cand_index, score_halves, last_rank, output ready);
endinterface

>>> rtl/core/copeland_score_ranker_core.sv
// Copeland score ranker: score memory with read-modify-write accumulation,
// selection ranking over the memory and a zeroing sweep. Uses csr_pkg,
// csr_entry_if and csr_rank_if.
//
//   channel   dir   handshake        payload
//   ent       in    valid/ready      row_cand, col_cand, margin, final_entry
//   rank      out   valid/ready      rank_pos, cand_index, score_halves, last_rank
//   apb       in    psel/penable     paddr, pwrite, pwdata -> prdata (pready tied high)
//
// Matrix entries are taken one per cycle while idle; a write-back forwarding register
// covers back-to-back hits on the same candidate in the registered-read score memory.
// After the final entry a drain step starts the ranking; each position then takes a
// scan of n memory reads, a pick step and an emit step; a zeroing sweep of all MAX_CAND
// entries follows. Reset starts with the same sweep; entries are refused meanwhile.
// A stalled rank beat holds the selector in its emit step; entries wait until done.
module copeland_score_ranker_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [csr_pkg::APB_AW-1:0] paddr,
	input  logic [csr_pkg::APB_DW-1:0] pwdata,
	output logic [csr_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	csr_entry_if.sink                  ent,
	csr_rank_if.source                 rank
);

	// Register port
	logic [csr_pkg::CFG_W-1:0] cand_count_q;
	logic                      cfg_sel;
	logic [csr_pkg::CNT_W-1:0] n_eff;
	logic [csr_pkg::CNT_W-1:0] n_last;

	// Controller
	csr_pkg::state_t state_q, state_d;
	logic ent_fire, start_rank, scan_end, emit_fire, clr_end;

	// Score memory ports
	logic [csr_pkg::SCORE_W-1:0] score_mem [csr_pkg::MAX_CAND];
	logic [csr_pkg::CAND_W-1:0]  rd_addr;
	logic [csr_pkg::SCORE_W-1:0] rd_data_q;
	logic                        wr_en;
	logic [csr_pkg::CAND_W-1:0]  wr_addr;
	logic [csr_pkg::SCORE_W-1:0] wr_data;

	// Accumulate stage
	logic                        hit;
	logic [1:0]                  add_amt;
	logic                        acc_vld_s1;
	logic [csr_pkg::CAND_W-1:0]  acc_row_s1;
	logic [1:0]                  acc_add_s1;
	logic [csr_pkg::SCORE_W-1:0] acc_base;
	logic [csr_pkg::SCORE_W:0]   acc_sum;
	logic [csr_pkg::SCORE_W-1:0] acc_new;
	logic                        fwd_vld_q;
	logic [csr_pkg::CAND_W-1:0]  fwd_row_q;
	logic [csr_pkg::SCORE_W-1:0] fwd_val_q;

	// Selection
	logic [csr_pkg::CNT_W-1:0]    rd_idx_q;
	logic                         rd_vld_s1;
	logic [csr_pkg::CAND_W-1:0]   rd_idx_s1;
	logic [csr_pkg::MAX_CAND-1:0] taken_q;
	logic                         best_vld_q;
	logic [csr_pkg::CAND_W-1:0]   best_idx_q;
	logic [csr_pkg::SCORE_W-1:0]  best_score_q;
	logic [csr_pkg::CNT_W-1:0]    rank_q;
	logic [csr_pkg::CAND_W-1:0]   clr_idx_q;
	logic                         out_free;

	// Output register
	logic                        out_vld_q;
	logic [csr_pkg::IDX_W-1:0]   out_pos_q;
	logic [csr_pkg::IDX_W-1:0]   out_cand_q;
	logic [csr_pkg::SOUT_W-1:0]  out_score_q;
	logic                        out_last_q;

	// APB: single register, decoded on the word address
	assign pready  = 1'b1;
	assign cfg_sel = (paddr[csr_pkg::APB_AW-1:2] == csr_pkg::REG_CAND_COUNT);
	assign prdata  = cfg_sel ? csr_pkg::APB_DW'(cand_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_count_q <= csr_pkg::CAND_COUNT_RST;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			cand_count_q <= pwdata[csr_pkg::CFG_W-1:0];
		end
	end

	// Clamp the candidate count into 1..MAX_CAND
	always_comb begin
		if (cand_count_q == '0) begin
			n_eff = csr_pkg::CNT_W'(1);
		end else if (int'(cand_count_q) > csr_pkg::MAX_CAND) begin
			n_eff = csr_pkg::CNT_W'(csr_pkg::MAX_CAND);
		end else begin
			n_eff = csr_pkg::CNT_W'(cand_count_q);
		end
	end
	assign n_last = n_eff - csr_pkg::CNT_W'(1);

	// Score contribution of the entry on the input channel
	always_comb begin
		hit = (ent.row_cand != ent.col_cand) && (int'(ent.row_cand) < int'(n_eff))
			&& (int'(ent.col_cand) < int'(n_eff));
		if (ent.margin == '0) begin
			add_amt = 2'd1;
		end else if (!ent.margin[csr_pkg::MARGIN_W-1]) begin
			add_amt = 2'd2;
		end else begin
			add_amt = 2'd0;
		end
	end

	assign ent.ready  = (state_q == csr_pkg::ST_IDLE);
	assign ent_fire   = ent.valid && ent.ready;
	assign out_free   = !out_vld_q || rank.ready;
	assign scan_end   = (rd_idx_q == n_last);
	assign clr_end    = (clr_idx_q == csr_pkg::CAND_W'(csr_pkg::MAX_CAND - 1));

	// Next state and step strobes
	always_comb begin
		state_d    = state_q;
		start_rank = 1'b0;
		emit_fire  = 1'b0;
		case (state_q)
			csr_pkg::ST_IDLE: begin
				if (ent_fire && ent.final_entry) begin
					state_d = csr_pkg::ST_DRAIN;
				end
			end
			csr_pkg::ST_DRAIN: begin
				start_rank = 1'b1;
				state_d    = csr_pkg::ST_SCAN;
			end
			csr_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = csr_pkg::ST_PICK;
				end
			end
			csr_pkg::ST_PICK: begin
				state_d = csr_pkg::ST_EMIT;
			end
			csr_pkg::ST_EMIT: begin
				if (out_free) begin
					emit_fire = 1'b1;
					state_d   = (rank_q == n_last) ? csr_pkg::ST_CLEAR : csr_pkg::ST_SCAN;
				end
			end
			csr_pkg::ST_CLEAR: begin
				if (clr_end) begin
					state_d = csr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csr_pkg::ST_IDLE;
			end
		endcase
	end

	// Hold state; reset enters the zeroing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Memory port selection: entry row while idle, scan index while ranking
	assign rd_addr = (state_q == csr_pkg::ST_IDLE) ? csr_pkg::CAND_W'(ent.row_cand)
		: rd_idx_q[csr_pkg::CAND_W-1:0];

	// Forward the last write-back when the same candidate follows directly
	assign acc_base = (fwd_vld_q && (fwd_row_q == acc_row_s1)) ? fwd_val_q : rd_data_q;
	assign acc_sum  = {1'b0, acc_base} + (csr_pkg::SCORE_W + 1)'(acc_add_s1);
	assign acc_new  = (int'(acc_sum) > csr_pkg::SCORE_CAP)
		? csr_pkg::SCORE_W'(csr_pkg::SCORE_CAP) : acc_sum[csr_pkg::SCORE_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = acc_row_s1;
		wr_data = acc_new;
		if (acc_vld_s1) begin
			wr_en = 1'b1;
		end else if (state_q == csr_pkg::ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_data = '0;
		end
	end

	// Score memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			score_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= score_mem[rd_addr];
	end

	// Accumulate pipeline and forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_s1 <= 1'b0;
			fwd_vld_q  <= 1'b0;
		end else begin
			acc_vld_s1 <= ent_fire && hit && (add_amt != 2'd0);
			if (acc_vld_s1) begin
				fwd_vld_q <= 1'b1;
			end else if (state_q == csr_pkg::ST_CLEAR) begin
				fwd_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_row_s1 <= csr_pkg::CAND_W'(ent.row_cand);
		acc_add_s1 <= add_amt;
		if (acc_vld_s1) begin
			fwd_row_q <= acc_row_s1;
			fwd_val_q <= acc_new;
		end
	end

	// Selection: scan counters, taken bits and the running best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			taken_q    <= '0;
			best_vld_q <= 1'b0;
			rank_q     <= '0;
			clr_idx_q  <= '0;
		end else begin
			rd_vld_s1 <= (state_q == csr_pkg::ST_SCAN);
			if (start_rank) begin
				rd_idx_q   <= '0;
				taken_q    <= '0;
				best_vld_q <= 1'b0;
				rank_q     <= '0;
			end else if (emit_fire) begin
				rd_idx_q             <= '0;
				taken_q[best_idx_q]  <= 1'b1;
				best_vld_q           <= 1'b0;
				rank_q               <= rank_q + csr_pkg::CNT_W'(1);
				clr_idx_q            <= '0;
			end else begin
				if (state_q == csr_pkg::ST_SCAN) begin
					rd_idx_q <= rd_idx_q + csr_pkg::CNT_W'(1);
				end
				if (rd_vld_s1 && !taken_q[rd_idx_s1]
					&& (!best_vld_q || (rd_data_q > best_score_q))) begin
					best_vld_q <= 1'b1;
				end
				if (state_q == csr_pkg::ST_CLEAR) begin
					clr_idx_q <= clr_idx_q + csr_pkg::CAND_W'(1);
				end
			end
		end
	end

	// Best candidate payload; strict compare keeps the lower index on ties
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q[csr_pkg::CAND_W-1:0];
		if (rd_vld_s1 && !taken_q[rd_idx_s1]
			&& (!best_vld_q || (rd_data_q > best_score_q))) begin
			best_idx_q   <= rd_idx_s1;
			best_score_q <= rd_data_q;
		end
	end

	// Output register: load on emit, drop on a taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_fire) begin
			out_vld_q <= 1'b1;
		end else if (rank.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_pos_q   <= csr_pkg::IDX_W'(rank_q);
			out_cand_q  <= csr_pkg::IDX_W'(best_idx_q);
			out_score_q <= csr_pkg::SOUT_W'(best_score_q);
			out_last_q  <= (rank_q == n_last);
		end
	end

	assign rank.valid        = out_vld_q;
	assign rank.rank_pos     = out_pos_q;
	assign rank.cand_index   = out_cand_q;
	assign rank.score_halves = out_score_q;
	assign rank.last_rank    = out_last_q;

`ifndef SYNTHESIS
	a_final_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		ent.valid && ent.ready && ent.final_entry |=> !ent.ready)
		else $error("entry accepted right after a final entry");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rank.valid && rank.last_rank |-> rank.rank_pos == csr_pkg::IDX_W'(n_last))
		else $error("last rank beat not at the final position");

	a_taken_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == csr_pkg::ST_SCAN |-> $countones(taken_q) == int'(rank_q))
		else $error("taken bits disagree with emitted positions");

	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		acc_vld_s1 |-> state_q != csr_pkg::ST_CLEAR)
		else $error("score write-back during zeroing sweep");
`endif

endmodule

>>> tb/copeland_score_ranker_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for copeland_score_ranker_core: streams margin matrix entries,
// predicts ranking beats from its own score model or hand-worked lists and checks them in order.
// Depends on csr_pkg, csr_entry_if, csr_rank_if and the core.
module copeland_score_ranker_core_test;

	// Sizes taken from the package
	localparam int MAX_CAND  = csr_pkg::MAX_CAND;
	localparam int SCORE_W   = csr_pkg::SCORE_W;
	localparam int SCORE_CAP = csr_pkg::SCORE_CAP;
	localparam int MARGIN_W  = csr_pkg::MARGIN_W;
	localparam int IDX_W     = csr_pkg::IDX_W;
	localparam int SOUT_W    = csr_pkg::SOUT_W;
	localparam int CFG_W     = csr_pkg::CFG_W;
	localparam int APB_AW    = csr_pkg::APB_AW;
	localparam int APB_DW    = csr_pkg::APB_DW;

	localparam real CLK_PERIOD = 12.0;
	localparam int RESET_CYCLES = 6;
	localparam int SETTLE_CYCLES = MAX_CAND + 16;
	localparam longint LIMIT_CYCLES = 20_000_000;
	localparam int ENTRY_TARGET = 500;
	localparam int HOLD_CYCLES = 600;
	localparam logic [APB_AW-1:0] COUNT_ADDR = {csr_pkg::REG_CAND_COUNT, 2'b00};

	typedef struct packed {
		logic [IDX_W-1:0]           row;
		logic [IDX_W-1:0]           col;
		logic signed [MARGIN_W-1:0] margin;
		logic                       fin;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0]  pos;
		logic [IDX_W-1:0]  cand;
		logic [SOUT_W-1:0] score;
		logic              last;
	} rank_beat_t;

	typedef enum {ROW_CFG, ROW_ENT} row_kind_t;
	typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

	// One directed step: a count write or an entry, optionally with a hand-worked ranking
	typedef struct {
		row_kind_t              kind;
		logic [CFG_W-1:0]       cfg;
		entry_t                 ent;
		int                     n_typed;
		logic [2:0][IDX_W-1:0]  exp_cand;
		logic [2:0][SOUT_W-1:0] exp_score;
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	csr_entry_if entry_bus();
	csr_rank_if  rank_bus();

	copeland_score_ranker_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ent     (entry_bus),
		.rank    (rank_bus)
	);

	// Score model state
	logic [CFG_W-1:0]   model_count;
	logic [SCORE_W-1:0] model_score [MAX_CAND];
	rank_beat_t         fresh_ranks[$];
	rank_beat_t         pending_ranks[$];

	int  fail_count = 0;
	int  entries_sent = 0;
	int  rankings_seen = 0;
	int  beats_checked = 0;
	int  cfg_writes = 0;
	int  tx_idle_pct = 0;
	int  rx_stall_pct = 0;
	int  hold_left = 0;
	bit  last_was_final = 1'b0;

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic int active_cands();
		if (model_count == 0)
			return 1;
		if (model_count > MAX_CAND)
			return MAX_CAND;
		return int'(model_count);
	endfunction

	// Count one entry; on a final entry rank into fresh_ranks and clear the scores
	function automatic int tally_entry(entry_t e);
		int                  n;
		int                  halves;
		int                  sum;
		int                  best;
		logic [MAX_CAND-1:0] placed;
		n = active_cands();
		placed = '0;
		halves = 0;
		if (e.margin == 0)
			halves = 1;
		else if ($signed(e.margin) > 0)
			halves = 2;
		if (e.row != e.col && e.row < n && e.col < n && halves > 0) begin
			sum = int'(model_score[e.row]) + halves;
			model_score[e.row] = (sum > SCORE_CAP) ? SCORE_W'(SCORE_CAP) : SCORE_W'(sum);
		end
		if (!e.fin)
			return 0;
		// Highest score first; the ascending scan keeps the lower index on ties
		for (int k = 0; k < n; k++) begin
			best = -1;
			for (int c = 0; c < n; c++)
				if (!placed[c] && (best < 0 || model_score[c] > model_score[best]))
					best = c;
			placed[best] = 1'b1;
			fresh_ranks.push_back('{pos: IDX_W'(k), cand: IDX_W'(best),
				score: SOUT_W'(model_score[best]), last: (k == n - 1)});
		end
		foreach (model_score[c])
			model_score[c] = '0;
		return n;
	endfunction

	function automatic script_row_t drow(row_kind_t kind, int cfg, int r, int c, int m,
			bit fin, int n_typed = 0, logic [2:0][IDX_W-1:0] cands = '0,
			logic [2:0][SOUT_W-1:0] scores = '0);
		script_row_t s;
		s.kind = kind;
		s.cfg = CFG_W'(cfg);
		s.ent = '{row: IDX_W'(r), col: IDX_W'(c), margin: MARGIN_W'(m), fin: fin};
		s.n_typed = n_typed;
		s.exp_cand = cands;
		s.exp_score = scores;
		return s;
	endfunction

	function automatic logic signed [MARGIN_W-1:0] pick_margin();
		return ($urandom_range(3) == 0) ? '0 : MARGIN_W'($urandom());
	endfunction

	// Drive rank ready: honor a long hold first, else stall at the phase rate
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rank_bus.ready <= 1'b0;
		end else begin
			rank_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Check each accepted rank beat against the oldest expectation
	always @(posedge clk) begin : rank_check
		rank_beat_t want;
		if (arst_n && rank_bus.valid && rank_bus.ready) begin
			beats_checked++;
			if (pending_ranks.size() == 0) begin
				report_mismatch("rank beat with nothing expected", rank_bus.cand_index, -1);
			end else begin
				want = pending_ranks.pop_front();
				if (rank_bus.rank_pos !== want.pos)
					report_mismatch("rank_pos", rank_bus.rank_pos, want.pos);
				if (rank_bus.cand_index !== want.cand)
					report_mismatch("cand_index", rank_bus.cand_index, want.cand);
				if (rank_bus.score_halves !== want.score)
					report_mismatch("score_halves", rank_bus.score_halves, want.score);
				if (rank_bus.last_rank !== want.last)
					report_mismatch("last_rank", rank_bus.last_rank, want.last);
			end
		end
	end

	// Offer one entry after random idle cycles and hold it until accepted
	task automatic send_entry(entry_t e);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			entry_bus.valid <= 1'b0;
			@(negedge clk);
		end
		entry_bus.valid <= 1'b1;
		entry_bus.row_cand <= e.row;
		entry_bus.col_cand <= e.col;
		entry_bus.margin <= e.margin;
		entry_bus.final_entry <= e.fin;
		@(posedge clk);
		while (!entry_bus.ready)
			@(posedge clk);
		entries_sent++;
		last_was_final = e.fin;
	endtask

	// Send one entry and queue whatever ranking it releases
	task automatic issue(entry_t e);
		send_entry(e);
		if (tally_entry(e) > 0)
			rankings_seen++;
		while (fresh_ranks.size() > 0)
			pending_ranks.push_back(fresh_ranks.pop_front());
	endtask

	// Drop valid, drain all rank beats and let the zeroing sweep finish
	task automatic settle();
		@(negedge clk);
		entry_bus.valid <= 1'b0;
		while (pending_ranks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the candidate count, then read it back
	task automatic write_count(logic [CFG_W-1:0] value);
		logic [APB_DW-1:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COUNT_ADDR;
		pwdata <= APB_DW'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		model_count = value;
		cfg_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		if (got !== APB_DW'(value))
			report_mismatch("candidate_count readback", got, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Full off-diagonal matrix with random margins, a few entries dropped
	task automatic run_matrix(int n);
		entry_t e;
		int     total;
		int     k;
		total = n * (n - 1);
		k = 0;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				if (r != c) begin
					k++;
					e = '{row: IDX_W'(r), col: IDX_W'(c), margin: pick_margin(),
						fin: (k == total)};
					if (e.fin || $urandom_range(9) != 0)
						issue(e);
				end
	endtask

	// Repeat one win until the row score saturates, then rank
	task automatic run_hammer(int n);
		entry_t e;
		int     reps;
		reps = $urandom_range(70, 64);
		e.row = IDX_W'($urandom_range(n - 1));
		do
			e.col = IDX_W'($urandom_range(n - 1));
		while (e.col == e.row);
		for (int i = 0; i < reps; i++) begin
			e.margin = MARGIN_W'($urandom_range(32767, 1));
			e.fin = (i == reps - 1);
			issue(e);
		end
	endtask

	// Loose entries, half within the active field; fin_odds of zero never ranks
	task automatic run_noise(int count, int n, int fin_odds);
		entry_t e;
		for (int i = 0; i < count; i++) begin
			e.row = IDX_W'($urandom_range(1) ? $urandom_range(n - 1) : $urandom_range(63));
			e.col = IDX_W'($urandom_range(1) ? $urandom_range(n - 1) : $urandom_range(63));
			e.margin = pick_margin();
			e.fin = (fin_odds > 0) && ($urandom_range(fin_odds - 1) == 0);
			issue(e);
		end
	endtask

	task automatic set_idle(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			IDLE_TX: begin
				tx_idle_pct = 87;
				rx_stall_pct = 0;
			end
			IDLE_RX: begin
				tx_idle_pct = 0;
				rx_stall_pct = 87;
			end
			default: begin
				tx_idle_pct = 22;
				rx_stall_pct = 22;
			end
		endcase
	endtask

	// Stop a hung run
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("status: fail");
		$finish;
	end

	initial begin
		script_row_t script[$];
		int          cfg_plan[$];
		int          n;
		int          phase;
		int          phase_start;
		int          pick;
		int          directed_entries;
		entry_t      e;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		entry_bus.valid = 1'b0;
		entry_bus.row_cand = '0;
		entry_bus.col_cand = '0;
		entry_bus.margin = '0;
		entry_bus.final_entry = 1'b0;
		rank_bus.ready = 1'b0;
		model_count = csr_pkg::CAND_COUNT_RST;
		foreach (model_score[c])
			model_score[c] = '0;

		// At the reset count: extreme candidates and margins
		script.push_back(drow(ROW_ENT, 0, 63, 0, 32767, 0));
		script.push_back(drow(ROW_ENT, 0, 0, 63, -32768, 1));
		// Three candidates: tie, win, diagonal, losses; equal scores by index
		script.push_back(drow(ROW_CFG, 3, 0, 0, 0, 0));
		script.push_back(drow(ROW_ENT, 0, 0, 1, 0, 0));
		script.push_back(drow(ROW_ENT, 0, 1, 0, 1, 0));
		script.push_back(drow(ROW_ENT, 0, 2, 2, 100, 0));
		script.push_back(drow(ROW_ENT, 0, 1, 2, -1, 0));
		script.push_back(drow(ROW_ENT, 0, 2, 0, -32768, 0));
		script.push_back(drow(ROW_ENT, 0, 2, 1, 32767, 1, 3,
			{6'd0, 6'd2, 6'd1}, {7'd1, 7'd2, 7'd2}));
		// Out-of-range candidates add nothing; a final diagonal entry still ranks
		script.push_back(drow(ROW_ENT, 0, 3, 0, 5, 0));
		script.push_back(drow(ROW_ENT, 0, 0, 5, 5, 0));
		script.push_back(drow(ROW_ENT, 0, 63, 63, 0, 1, 3,
			{6'd2, 6'd1, 6'd0}, '0));
		// Count zero acts as one candidate
		script.push_back(drow(ROW_CFG, 0, 0, 0, 0, 0));
		script.push_back(drow(ROW_ENT, 0, 0, 1, 7, 0));
		script.push_back(drow(ROW_ENT, 0, 0, 0, 1, 1, 1, '0, '0));
		// Largest count saturates to the full field
		script.push_back(drow(ROW_CFG, 127, 0, 0, 0, 0));
		script.push_back(drow(ROW_ENT, 0, 62, 63, 0, 0));
		script.push_back(drow(ROW_ENT, 0, 5, 7, -5, 0));
		script.push_back(drow(ROW_ENT, 0, 40, 3, 2, 1));
		// Two candidates: win beats loss
		script.push_back(drow(ROW_CFG, 2, 0, 0, 0, 0));
		script.push_back(drow(ROW_ENT, 0, 1, 0, 1, 0));
		script.push_back(drow(ROW_ENT, 0, 0, 1, -1, 1, 2,
			{6'd0, 6'd0, 6'd1}, {7'd0, 7'd0, 7'd2}));
		// Just past the limit
		script.push_back(drow(ROW_CFG, 65, 0, 0, 0, 0));
		script.push_back(drow(ROW_ENT, 0, 0, 63, 1, 1));

		cfg_plan = '{5, 2, 64, 1, 8, 127, 3, 0, 65, 6, 4, 7};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, no idling
		set_idle(IDLE_NONE);
		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				settle();
				write_count(script[i].cfg);
			end else if (script[i].n_typed == 0) begin
				issue(script[i].ent);
			end else begin
				// Hand-worked ranking stands in for the prediction
				send_entry(script[i].ent);
				void'(tally_entry(script[i].ent));
				fresh_ranks.delete();
				rankings_seen++;
				for (int k = 0; k < script[i].n_typed; k++)
					pending_ranks.push_back('{pos: IDX_W'(k), cand: script[i].exp_cand[k],
						score: script[i].exp_score[k], last: (k == script[i].n_typed - 1)});
			end
		end
		directed_entries = entries_sent;

		// Random phases, each under its own count and idling pattern
		phase = 0;
		while (entries_sent < directed_entries + ENTRY_TARGET) begin
			set_idle(idle_mode_t'(phase % 4));
			settle();
			if (phase < cfg_plan.size())
				write_count(CFG_W'(cfg_plan[phase]));
			else
				write_count(CFG_W'($urandom_range(9, 2)));
			n = active_cands();
			phase_start = entries_sent;

			if (phase == 0) begin
				// Hold rank ready off so the ranking backs up into the entry channel
				@(posedge clk);
				hold_left = HOLD_CYCLES;
				run_matrix(n);
				run_noise(20, n, 0);
				// Pause until the held ranking has fully drained
				while (pending_ranks.size() != 0)
					@(posedge clk);
			end

			while (entries_sent - phase_start < 50) begin
				pick = $urandom_range(99);
				if (pick < 55 && n >= 2 && n <= 8)
					run_matrix(n);
				else if (pick < 70 && n >= 2)
					run_hammer(n);
				else
					run_noise($urandom_range(12, 4), n, (n > 16) ? 24 : 8);
			end

			// Close the phase with a ranking so the store starts clean
			if (!last_was_final) begin
				e = '{row: IDX_W'($urandom_range(63)), col: IDX_W'($urandom_range(63)),
					margin: pick_margin(), fin: 1'b1};
				issue(e);
			end
			phase++;
		end

		@(negedge clk);
		entry_bus.valid <= 1'b0;
		while (pending_ranks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d matrix entries, %0d rankings and %0d rank beats over %0d count writes",
			entries_sent, rankings_seen, beats_checked, cfg_writes);
		$display("counts from zero to past the limit, saturated scores, four idling patterns");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/csr_pkg.sv
rtl/core/csr_entry_if.sv
rtl/core/csr_rank_if.sv
rtl/core/copeland_score_ranker_core.sv
tb/copeland_score_ranker_core_test.sv
